>>> src/slrg_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// slrg_pkg - shared definitions for the subtractive lagged generator
// Table geometry, modulus and seed constants, and the modular fold helper.
// ----------------------------------------------------------------------------
package slrg_pkg;

    localparam int unsigned WORD_W      = 32;
    localparam int unsigned SAMPLE_W    = 31;
    localparam int unsigned ADDR_W      = 6;
    localparam int unsigned TABLE_DEPTH = 56;

    localparam logic [WORD_W-1:0] MODULUS     = 32'd2147483647;
    localparam logic [WORD_W-1:0] MODULUS_X2  = 32'd4294967294;
    localparam logic [WORD_W-1:0] SEED_BASE   = 32'd161803398;

    localparam logic [ADDR_W-1:0] SCATTER_STRIDE = 6'd21;
    localparam logic [ADDR_W-1:0] SCATTER_WRAP   = 6'd55;
    localparam logic [5:0]        SCATTER_STEPS  = 6'd54;
    localparam logic [ADDR_W-1:0] LAST_ENTRY     = 6'd55;
    localparam logic [ADDR_W-1:0] POINTER_WRAP   = 6'd56;
    localparam logic [ADDR_W-1:0] MIX_OTHER_INIT = 6'd32;
    localparam logic [1:0]        LAST_PASS      = 2'd3;
    localparam logic [ADDR_W-1:0] LEAD_RESET     = 6'd0;
    localparam logic [ADDR_W-1:0] LAG_RESET      = 6'd21;

    localparam logic OP_RESEED = 1'b0;
    localparam logic OP_DRAW   = 1'b1;

    // Bring a wrapped difference back into range: add the modulus when negative
    function automatic logic [WORD_W-1:0] slrg_fold(input logic [WORD_W-1:0] d);
        logic [WORD_W-1:0] r;
        r = d[WORD_W-1] ? (d + MODULUS) : d;
        return r;
    endfunction

    // Advance a table pointer, wrapping from the end of the table back to one
    function automatic logic [ADDR_W-1:0] slrg_advance(input logic [ADDR_W-1:0] p);
        logic [ADDR_W-1:0] r;
        r = p + 6'd1;
        if (r >= POINTER_WRAP) begin
            r = 6'd1;
        end
        return r;
    endfunction

endpackage

>>> src/subtractive_lagged_random_generator.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// subtractive_lagged_random_generator - lag 55/34 subtractive generator
// Sequenced around one shared subtract-and-fold unit and a 56-entry table.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (i_in_valid / o_in_ready) takes one transaction per item.
//   i_op = reseed fills the table from i_seed_value and returns nothing;
//   i_op = draw returns one transaction on the output channel (o_out_valid /
//   i_out_ready) carrying the raw value and the value scaled into [i_range_low,
//   i_range_high), or (high, low] if high < low, by an exact integer floor.
//   Draw: accepted, then table read, subtract and write-back, 31x31 multiply,
//   reduction by the modulus and the final offset add; the result is
//   presented, and o_in_ready returns, in the same cycle.
//   Reseed: seed the last entry, scatter through the table, then four
//   mixing passes of 55 entries, each a registered table read and then a
//   write, before o_in_ready returns.
//   The table memory has two registered read ports and one write port; its
//   registered reads split each mixing step into a read and a write state.
//   Reset clears the sequencer, the output valid and the pointers to 0 and 21;
//   the table itself holds garbage until the first reseed, so draws before
//   it return undefined values.
//   A stalled receiver holds the result in the output register; the block
//   still takes a new transaction, and a draw waits in its last step until
//   the output register frees.
// ----------------------------------------------------------------------------
module subtractive_lagged_random_generator
    import slrg_pkg::*;
(
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_in_valid,
    output logic                       o_in_ready,
    input  logic                       i_op,
    input  logic [SAMPLE_W-1:0]        i_seed_value,
    input  logic signed [SAMPLE_W-1:0] i_range_low,
    input  logic signed [SAMPLE_W-1:0] i_range_high,
    output logic                       o_out_valid,
    input  logic                       i_out_ready,
    output logic [SAMPLE_W-1:0]        o_raw_sample,
    output logic signed [SAMPLE_W-1:0] o_scaled_sample
);

    // Sequencer states
    localparam logic [3:0] S_IDLE      = 4'd0;
    localparam logic [3:0] S_SEED_INIT = 4'd1;
    localparam logic [3:0] S_SCATTER   = 4'd2;
    localparam logic [3:0] S_MIX_RD    = 4'd3;
    localparam logic [3:0] S_MIX_WR    = 4'd4;
    localparam logic [3:0] S_DRAW_RD   = 4'd5;
    localparam logic [3:0] S_DRAW_WR   = 4'd6;
    localparam logic [3:0] S_MUL       = 4'd7;
    localparam logic [3:0] S_DIV       = 4'd8;
    localparam logic [3:0] S_OUT       = 4'd9;

    logic [3:0]  r_state, n_state;

    // Control state
    logic [ADDR_W-1:0] r_lead, n_lead;
    logic [ADDR_W-1:0] r_lag, n_lag;
    logic [ADDR_W-1:0] r_pos, n_pos;
    logic [5:0]        r_cnt, n_cnt;
    logic [ADDR_W-1:0] r_k, n_k;
    logic [ADDR_W-1:0] r_other, n_other;
    logic [1:0]        r_pass, n_pass;
    logic              r_out_valid;

    // Datapath registers
    logic [WORD_W-1:0]          r_prev, r_carry;
    logic signed [SAMPLE_W-1:0] r_low, r_high;
    logic [WORD_W-1:0]          r_span;
    logic [SAMPLE_W-1:0]        r_mag;
    logic [SAMPLE_W-1:0]        r_raw;
    logic [2*SAMPLE_W-1:0]      r_prod;
    logic [SAMPLE_W-1:0]        r_quot;
    logic [SAMPLE_W-1:0]        r_out_raw;
    logic [SAMPLE_W-1:0]        r_out_scaled;

    // Table memory
    logic [WORD_W-1:0] r_table [TABLE_DEPTH];
    logic [WORD_W-1:0] r_rd_a, r_rd_b;
    logic [ADDR_W-1:0] rd_addr_a, rd_addr_b;
    logic              mem_we;
    logic [ADDR_W-1:0] mem_waddr;
    logic [WORD_W-1:0] mem_wdata;

    // Shared subtract-and-fold unit
    logic [WORD_W-1:0] unit_a, unit_b, unit_diff, unit_fold, draw_val;

    logic in_accept;
    logic out_load;
    logic [ADDR_W:0]   scatter_sum;
    logic [ADDR_W-1:0] scatter_pos;
    logic [WORD_W-1:0] low_ext, high_ext;
    logic [WORD_W-1:0] red_sum;
    logic [SAMPLE_W-1:0] red_a, red_b;
    logic [1:0] red_carry;
    logic [SAMPLE_W-1:0] scaled_val;

    assign o_in_ready  = (r_state == S_IDLE);
    assign in_accept   = i_in_valid && o_in_ready;
    assign out_load    = (r_state == S_OUT) && (!r_out_valid || i_out_ready);
    assign o_out_valid = r_out_valid;
    assign o_raw_sample    = r_out_raw;
    assign o_scaled_sample = r_out_scaled;

    // Scatter position: step by the stride, wrap at 55 (one spare bit for the sum)
    always_comb begin
        scatter_sum = {1'b0, r_pos} + {1'b0, SCATTER_STRIDE};
        if (scatter_sum >= {1'b0, SCATTER_WRAP}) begin
            scatter_sum = scatter_sum - {1'b0, SCATTER_WRAP};
        end
        scatter_pos = scatter_sum[ADDR_W-1:0];
    end

    // Operand select for the shared unit: scatter works from registers,
    // mixing and drawing from the two table read ports
    always_comb begin
        if (r_state == S_SCATTER) begin
            unit_a = r_prev;
            unit_b = r_carry;
        end else begin
            unit_a = r_rd_a;
            unit_b = r_rd_b;
        end
        unit_diff = unit_a - unit_b;
        unit_fold = slrg_fold(unit_diff);
        // A draw maps a difference equal to the modulus one below it
        draw_val  = (unit_diff == MODULUS) ? (MODULUS - 32'd1) : unit_fold;
    end

    // Read addresses: mixing reads entry k and its partner, drawing the pointers
    assign rd_addr_a = (r_state == S_MIX_RD) ? r_k : r_lead;
    assign rd_addr_b = (r_state == S_MIX_RD) ? r_other : r_lag;

    // Write port
    always_comb begin
        mem_we    = 1'b0;
        mem_waddr = r_k;
        mem_wdata = unit_fold;
        unique case (r_state)
            S_SEED_INIT: begin
                mem_we    = 1'b1;
                mem_waddr = LAST_ENTRY;
                mem_wdata = r_prev;
            end
            S_SCATTER: begin
                mem_we    = 1'b1;
                mem_waddr = scatter_pos;
                mem_wdata = r_carry;
            end
            S_MIX_WR: begin
                mem_we    = 1'b1;
                mem_waddr = r_k;
                mem_wdata = unit_fold;
            end
            S_DRAW_WR: begin
                mem_we    = 1'b1;
                mem_waddr = r_lead;
                mem_wdata = draw_val;
            end
            default: begin
                mem_we = 1'b0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_table[mem_waddr] <= mem_wdata;
        end
        r_rd_a <= r_table[rd_addr_a];
        r_rd_b <= r_table[rd_addr_b];
    end

    // Reduction of the 62-bit product by 2^31-1: p = a*2^31 + b gives
    // p = a*M + (a + b), and a + b stays below 2M + 2
    always_comb begin
        red_a   = r_prod[2*SAMPLE_W-1:SAMPLE_W];
        red_b   = r_prod[SAMPLE_W-1:0];
        red_sum = {1'b0, red_a} + {1'b0, red_b};
        if (red_sum >= MODULUS_X2) begin
            red_carry = 2'd2;
        end else if (red_sum >= MODULUS) begin
            red_carry = 2'd1;
        end else begin
            red_carry = 2'd0;
        end
    end

    // Apply the sign of the span and the lower bound in one add or subtract
    assign scaled_val = r_span[WORD_W-1] ? (r_low - r_quot) : (r_low + r_quot);

    assign low_ext  = {{(WORD_W-SAMPLE_W){r_low[SAMPLE_W-1]}}, r_low};
    assign high_ext = {{(WORD_W-SAMPLE_W){r_high[SAMPLE_W-1]}}, r_high};

    // Sequencer next state
    always_comb begin
        n_state = r_state;
        n_lead  = r_lead;
        n_lag   = r_lag;
        n_pos   = r_pos;
        n_cnt   = r_cnt;
        n_k     = r_k;
        n_other = r_other;
        n_pass  = r_pass;
        unique case (r_state)
            S_IDLE: begin
                if (in_accept) begin
                    if (i_op == OP_DRAW) begin
                        // Advance both pointers before the reads
                        n_lead  = slrg_advance(r_lead);
                        n_lag   = slrg_advance(r_lag);
                        n_state = S_DRAW_RD;
                    end else begin
                        n_state = S_SEED_INIT;
                    end
                end
            end
            S_SEED_INIT: begin
                n_pos   = '0;
                n_cnt   = '0;
                n_state = S_SCATTER;
            end
            S_SCATTER: begin
                n_pos = scatter_pos;
                n_cnt = r_cnt + 6'd1;
                if (r_cnt == SCATTER_STEPS - 6'd1) begin
                    n_k     = 6'd1;
                    n_other = MIX_OTHER_INIT;
                    n_pass  = '0;
                    n_state = S_MIX_RD;
                end
            end
            S_MIX_RD: begin
                n_state = S_MIX_WR;
            end
            S_MIX_WR: begin
                n_other = slrg_advance(r_other);
                if (r_k == LAST_ENTRY) begin
                    n_k     = 6'd1;
                    n_other = MIX_OTHER_INIT;
                    n_pass  = r_pass + 2'd1;
                    if (r_pass == LAST_PASS) begin
                        // Table ready: restart the draw pointers
                        n_lead  = LEAD_RESET;
                        n_lag   = LAG_RESET;
                        n_state = S_IDLE;
                    end else begin
                        n_state = S_MIX_RD;
                    end
                end else begin
                    n_k     = r_k + 6'd1;
                    n_state = S_MIX_RD;
                end
            end
            S_DRAW_RD: begin
                n_state = S_DRAW_WR;
            end
            S_DRAW_WR: begin
                n_state = S_MUL;
            end
            S_MUL: begin
                n_state = S_DIV;
            end
            S_DIV: begin
                n_state = S_OUT;
            end
            S_OUT: begin
                if (out_load) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // Control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_lead      <= LEAD_RESET;
            r_lag       <= LAG_RESET;
            r_pos       <= '0;
            r_cnt       <= '0;
            r_k         <= 6'd1;
            r_other     <= MIX_OTHER_INIT;
            r_pass      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_lead  <= n_lead;
            r_lag   <= n_lag;
            r_pos   <= n_pos;
            r_cnt   <= n_cnt;
            r_k     <= n_k;
            r_other <= n_other;
            r_pass  <= n_pass;
            if (out_load) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Datapath registers
    always_ff @(posedge i_clk) begin
        if (in_accept) begin
            r_low  <= i_range_low;
            r_high <= i_range_high;
            r_prev <= SEED_BASE - {{(WORD_W-SAMPLE_W){1'b0}}, i_seed_value};
        end
        if (r_state == S_SEED_INIT) begin
            r_carry <= 32'd1;
        end
        if (r_state == S_SCATTER) begin
            // Hold the written value as the next minuend, advance the carry
            r_prev  <= r_carry;
            r_carry <= unit_fold;
        end
        if (r_state == S_DRAW_RD) begin
            r_span <= high_ext - low_ext;
        end
        if (r_state == S_DRAW_WR) begin
            r_raw <= draw_val[SAMPLE_W-1:0];
            r_mag <= r_span[WORD_W-1] ? SAMPLE_W'(32'd0 - r_span) : r_span[SAMPLE_W-1:0];
        end
        if (r_state == S_MUL) begin
            r_prod <= r_raw * r_mag;
        end
        if (r_state == S_DIV) begin
            r_quot <= red_a + {{(SAMPLE_W-2){1'b0}}, red_carry};
        end
        if (out_load) begin
            r_out_raw    <= r_raw;
            r_out_scaled <= scaled_val;
        end
    end

    // ------------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------------
    a_pointers_apart: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_lead <= LAST_ENTRY) && (r_lag <= LAST_ENTRY) && (r_lead != r_lag))
        else $error("draw pointers out of range or coincident");

    a_out_from_last_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_out_valid) |-> ($past(r_state) == S_OUT))
        else $error("result raised outside the output step");

    a_write_in_table: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        mem_we |-> (mem_waddr <= LAST_ENTRY))
        else $error("table write beyond last entry");

    a_mix_index: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ((r_state == S_MIX_RD) || (r_state == S_MIX_WR)) |->
        ((r_k >= 6'd1) && (r_k <= LAST_ENTRY) && (r_other >= 6'd1)
         && (r_other <= LAST_ENTRY)))
        else $error("mixing index out of range");

    a_draw_held_output: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ((r_state == S_OUT) && r_out_valid && !i_out_ready) |=> (r_state == S_OUT))
        else $error("draw left its last step while the output was stalled");

endmodule
